// ===== rtl/core/isingm_pkg.sv =====
package isingm_pkg;

  // lattice geometry
  localparam int SIDE   = 64;
  localparam int ADDR_W = (SIDE > 1) ? $clog2(SIDE) : 1;

  // fixed field widths
  localparam int FUNC_W  = 2;
  localparam int ROW_W   = 6;
  localparam int COL_W   = 6;
  localparam int J_W     = 6;
  localparam int FRAC_W  = 32;
  localparam int DE_W    = 9;
  localparam int CFG_I_W = 2;
  localparam int CFG_D_W = 32;

  // coupling clamp limits
  localparam logic signed [J_W-1:0] J_MAX = 6'sd16;
  localparam logic signed [J_W-1:0] J_MIN = -6'sd16;
  localparam logic signed [J_W-1:0] J_RESET = 6'sd1;

  typedef logic [SIDE-1:0]   row_word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // operation codes, code 3 behaves as a read
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_FLIP  = 2'd2
  } func_t;

  // configuration register indexes
  typedef enum logic [CFG_I_W-1:0] {
    CFG_COUPLING     = 2'd0,
    CFG_THRESH_FOUR  = 2'd1,
    CFG_THRESH_EIGHT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [J_W-1:0] coupling;
    logic [FRAC_W-1:0]     thresh_four;
    logic [FRAC_W-1:0]     thresh_eight;
  } cfg_regs_t;

  // site spin and its four wrap-around neighbors
  typedef struct packed {
    logic center;
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_t;

  typedef struct packed {
    logic                   accept;
    logic signed [DE_W-1:0] de;
  } eval_t;

endpackage

// ===== rtl/core/isingm_item_if.sv =====
interface isingm_item_if;
  logic                           valid;
  logic                           ready;
  logic [isingm_pkg::FUNC_W-1:0]  func;
  logic [isingm_pkg::ROW_W-1:0]   row;
  logic [isingm_pkg::COL_W-1:0]   col;
  logic                           spin_in;
  logic [isingm_pkg::FRAC_W-1:0]  random_fraction;

  modport source(output valid, func, row, col, spin_in, random_fraction, input ready);
  modport sink(input valid, func, row, col, spin_in, random_fraction, output ready);
endinterface

interface isingm_result_if;
  logic                                valid;
  logic                                ready;
  logic                                spin_out;
  logic                                flipped;
  logic signed [isingm_pkg::DE_W-1:0]  energy_change;

  modport source(output valid, spin_out, flipped, energy_change, input ready);
  modport sink(input valid, spin_out, flipped, energy_change, output ready);
endinterface

interface isingm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [isingm_pkg::CFG_I_W-1:0]  index;
  logic [isingm_pkg::CFG_D_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/isingm_row_ram.sv =====
module isingm_row_ram (
  input  logic                  clk,
  input  logic                  we,
  input  isingm_pkg::addr_t     waddr,
  input  isingm_pkg::row_word_t wdata,
  input  logic                  re,
  input  isingm_pkg::addr_t     raddr,
  output isingm_pkg::row_word_t rdata
);

  // one lattice row per word
  isingm_pkg::row_word_t mem [isingm_pkg::SIDE];
  isingm_pkg::row_word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/isingm_flip_eval.sv =====
module isingm_flip_eval (
  input  isingm_pkg::nbr_t                   nbr,
  input  isingm_pkg::cfg_regs_t              cfg,
  input  logic [isingm_pkg::FRAC_W-1:0]      rnd,
  output isingm_pkg::eval_t                  ev
);

  logic [2:0]                          ones;
  logic signed [5:0]                   four_n;
  logic signed [5:0]                   raw;
  logic signed [isingm_pkg::J_W-1:0]   j_clamped;
  logic signed [11:0]                  prod;
  logic                                mag_four;
  logic                                below_thr;

  // neighbor count and raw change 2*s*sum, sum = 2*ones - 4
  always_comb begin
    ones   = 3'(nbr.up) + 3'(nbr.dn) + 3'(nbr.lf) + 3'(nbr.rt);
    four_n = $signed({1'b0, ones, 2'b00});
    raw    = nbr.center ? (four_n - 6'sd8) : (6'sd8 - four_n);
  end

  // clamp coupling and scale
  always_comb begin
    if (cfg.coupling > isingm_pkg::J_MAX) begin
      j_clamped = isingm_pkg::J_MAX;
    end else if (cfg.coupling < isingm_pkg::J_MIN) begin
      j_clamped = isingm_pkg::J_MIN;
    end else begin
      j_clamped = cfg.coupling;
    end
    prod = j_clamped * raw;
  end

  // acceptance test against the threshold of the energy level
  always_comb begin
    mag_four  = (ones == 3'd1) || (ones == 3'd3);
    below_thr = mag_four ? (rnd < cfg.thresh_four) : (rnd < cfg.thresh_eight);
    ev.accept = (prod <= 12'sd0) || below_thr;
    ev.de     = isingm_pkg::DE_W'(prod);
  end

endmodule

// ===== rtl/core/ising_metropolis_site_update_core.sv =====
// in-range flip attempt: S_IDLE takes it, then S_RD_MID, S_RD_DN, S_EVAL and back to S_IDLE
// write, read and out-of-range items: S_IDLE takes them, then S_EVAL and back to S_IDLE
// one item at a time; the single read port of the row memory sets the rate
// a waiting result does not block acceptance; only the write-back waits for the output slot
// reset sets the coupling to one and zeroes both thresholds; a clearing pass over all SIDE
// rows (64) then zeroes the lattice while no item is accepted; configuration writes are taken at any time
module ising_metropolis_site_update_core (
  input  logic                   clk,
  input  logic                   rst_n,
  isingm_item_if.sink            in_chan,
  isingm_result_if.source        out_chan,
  isingm_cfg_if.sink             cfg_chan
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_RD_MID = 5'b00100,
    S_RD_DN  = 5'b01000,
    S_EVAL   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  isingm_pkg::cfg_regs_t cfg_r, cfg_nxt;

  // item registers
  logic [isingm_pkg::FUNC_W-1:0]  func_r;
  isingm_pkg::addr_t              row_r;
  isingm_pkg::addr_t              col_r;
  logic                           spin_in_r;
  logic [isingm_pkg::FRAC_W-1:0]  rnd_r;
  logic                           in_range_r;
  logic                           up_bit_r;
  isingm_pkg::row_word_t          mid_r;
  isingm_pkg::addr_t              clr_cnt_r;

  // output slot
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 spin_out_r;
  logic                                 flipped_r;
  logic signed [isingm_pkg::DE_W-1:0]   de_r;

  // memory port
  logic                   mem_we;
  isingm_pkg::addr_t      mem_waddr;
  isingm_pkg::row_word_t  mem_wdata;
  logic                   mem_re;
  isingm_pkg::addr_t      mem_raddr;
  isingm_pkg::row_word_t  mem_rdata;

  logic                   in_txn;
  logic                   in_range;
  logic                   is_flip;
  logic                   is_write;
  isingm_pkg::addr_t      in_row;
  isingm_pkg::addr_t      in_up;
  isingm_pkg::addr_t      row_dn;
  isingm_pkg::addr_t      col_lf;
  isingm_pkg::addr_t      col_rt;
  isingm_pkg::row_word_t  mid_row;
  isingm_pkg::row_word_t  new_row;
  logic                   new_bit;
  logic                   out_free;
  logic                   out_load;
  isingm_pkg::nbr_t       nbr;
  isingm_pkg::eval_t      ev;

  // configuration registers
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        isingm_pkg::CFG_COUPLING:     cfg_nxt.coupling = isingm_pkg::J_W'(cfg_chan.data);
        isingm_pkg::CFG_THRESH_FOUR:  cfg_nxt.thresh_four = cfg_chan.data;
        isingm_pkg::CFG_THRESH_EIGHT: cfg_nxt.thresh_eight = cfg_chan.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coupling     <= isingm_pkg::J_RESET;
      cfg_r.thresh_four  <= '0;
      cfg_r.thresh_eight <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input decode and wrap-around addresses
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_txn        = in_chan.valid && in_chan.ready;
  assign in_range      = (32'(in_chan.row) < isingm_pkg::SIDE) &&
                         (32'(in_chan.col) < isingm_pkg::SIDE);
  assign in_row        = isingm_pkg::ADDR_W'(in_chan.row);
  assign in_up         = (in_row == '0) ? isingm_pkg::ADDR_W'(isingm_pkg::SIDE - 1)
                                        : in_row - isingm_pkg::ADDR_W'(1);
  assign row_dn        = (row_r == isingm_pkg::ADDR_W'(isingm_pkg::SIDE - 1)) ? '0
                                        : row_r + isingm_pkg::ADDR_W'(1);
  assign col_lf        = (col_r == '0) ? isingm_pkg::ADDR_W'(isingm_pkg::SIDE - 1)
                                       : col_r - isingm_pkg::ADDR_W'(1);
  assign col_rt        = (col_r == isingm_pkg::ADDR_W'(isingm_pkg::SIDE - 1)) ? '0
                                       : col_r + isingm_pkg::ADDR_W'(1);
  assign is_flip       = (func_r == isingm_pkg::FUNC_FLIP);
  assign is_write      = (func_r == isingm_pkg::FUNC_WRITE);

  // evaluation of the addressed site
  assign mid_row    = is_flip ? mid_r : mem_rdata;
  assign nbr.center = mid_row[col_r];
  assign nbr.up     = up_bit_r;
  assign nbr.dn     = mem_rdata[col_r];
  assign nbr.lf     = mid_row[col_lf];
  assign nbr.rt     = mid_row[col_rt];

  isingm_flip_eval u_eval (
    .nbr (nbr),
    .cfg (cfg_r),
    .rnd (rnd_r),
    .ev  (ev)
  );

  always_comb begin
    if (is_write) begin
      new_bit = spin_in_r;
    end else if (is_flip) begin
      new_bit = nbr.center ^ ev.accept;
    end else begin
      new_bit = nbr.center;
    end
    new_row        = mid_row;
    new_row[col_r] = new_bit;
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign out_load = (state_r == S_EVAL) && out_free;

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = row_r;
    mem_we    = 1'b0;
    mem_waddr = row_r;
    mem_wdata = new_row;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      S_IDLE: begin
        mem_re    = in_txn && in_range;
        mem_raddr = (in_chan.func == isingm_pkg::FUNC_FLIP) ? in_up : in_row;
      end
      S_RD_MID: begin
        mem_re    = 1'b1;
        mem_raddr = row_r;
      end
      S_RD_DN: begin
        mem_re    = 1'b1;
        mem_raddr = row_dn;
      end
      S_EVAL: begin
        mem_we = out_load && in_range_r && (is_write || (is_flip && ev.accept));
      end
      default: ;
    endcase
  end

  isingm_row_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == isingm_pkg::ADDR_W'(isingm_pkg::SIDE - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_txn) begin
          if (in_range && (in_chan.func == isingm_pkg::FUNC_FLIP)) begin
            state_nxt = S_RD_MID;
          end else begin
            state_nxt = S_EVAL;
          end
        end
      end
      S_RD_MID: state_nxt = S_RD_DN;
      S_RD_DN:  state_nxt = S_EVAL;
      S_EVAL: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + isingm_pkg::ADDR_W'(1);
      end
    end
  end

  // item capture and neighbor rows
  always_ff @(posedge clk) begin
    if (in_txn) begin
      func_r     <= in_chan.func;
      row_r      <= in_row;
      col_r      <= isingm_pkg::ADDR_W'(in_chan.col);
      spin_in_r  <= in_chan.spin_in;
      rnd_r      <= in_chan.random_fraction;
      in_range_r <= in_range;
    end
    if (state_r == S_RD_MID) begin
      up_bit_r <= mem_rdata[col_r];
    end
    if (state_r == S_RD_DN) begin
      mid_r <= mem_rdata;
    end
  end

  // output slot
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      spin_out_r <= in_range_r && new_bit;
      flipped_r  <= in_range_r && is_flip && ev.accept;
      de_r       <= (in_range_r && is_flip) ? ev.de : '0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.spin_out      = spin_out_r;
  assign out_chan.flipped       = flipped_r;
  assign out_chan.energy_change = de_r;

`ifndef SYNTHESIS
  // memory writes only during the clearing pass or the write-back
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_EVAL))
    else $error("lattice write outside clear or write-back");

  // the memory never reads and writes in one cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("lattice read and write collide");

  // a loaded result is presented and the sequencer returns to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_chan.valid && state_r == S_IDLE))
    else $error("result not presented after write-back");

  // no item is taken during the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_chan.ready)
    else $error("input ready during lattice clear");
`endif

endmodule

// ===== test/isingm_checker.sv =====
module isingm_checker
  import isingm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  isingm_item_if   in_mon,
  isingm_result_if out_mon,
  isingm_cfg_if    cfg_mon,
  output int       pending,
  output int       mismatches
);

  typedef struct packed {
    logic                   spin;
    logic                   flip;
    logic signed [DE_W-1:0] de;
  } site_outcome_t;

  localparam int RING_DEPTH = 64;

  // local copy of the lattice and the registers
  logic              lattice [SIDE][SIDE];
  int                coupling_j;
  logic [FRAC_W-1:0] thr_four;
  logic [FRAC_W-1:0] thr_eight;

  // predicted outcomes in arrival order
  site_outcome_t     ring [RING_DEPTH];
  int                ring_head;
  int                ring_count;

  // +1 / -1 value of a stored spin bit
  function automatic int spin_pm(input logic b);
    return b ? 1 : -1;
  endfunction

  // apply one transaction to the local lattice, return the outcome it produces
  function automatic site_outcome_t update_site(
    input logic [FUNC_W-1:0] op,
    input logic [ROW_W-1:0]  r,
    input logic [COL_W-1:0]  c,
    input logic              spin_wr,
    input logic [FRAC_W-1:0] frac
  );
    site_outcome_t res;
    int ri, ci, nsum, raw, j, de;
    logic take;
    res = '0;
    ri = int'(r);
    ci = int'(c);
    if (ri >= SIDE || ci >= SIDE) return res;
    if (op == FUNC_WRITE) begin
      lattice[ri][ci] = spin_wr;
    end else if (op == FUNC_FLIP) begin
      // wrap-around neighbor sum
      nsum = spin_pm(lattice[(ri + SIDE - 1) % SIDE][ci])
           + spin_pm(lattice[(ri + 1) % SIDE][ci])
           + spin_pm(lattice[ri][(ci + SIDE - 1) % SIDE])
           + spin_pm(lattice[ri][(ci + 1) % SIDE]);
      raw = 2 * spin_pm(lattice[ri][ci]) * nsum;
      // coupling saturates at the clamp limits
      j = coupling_j;
      if (j > int'(J_MAX)) j = int'(J_MAX);
      if (j < int'(J_MIN)) j = int'(J_MIN);
      de = j * raw;
      if (de <= 0)
        take = 1'b1;
      else if (raw == 4 || raw == -4)
        take = frac < thr_four;
      else
        take = frac < thr_eight;
      if (take) begin
        lattice[ri][ci] = ~lattice[ri][ci];
        res.flip = 1'b1;
      end
      res.de = DE_W'(de);
    end
    res.spin = lattice[ri][ci];
    return res;
  endfunction

  always @(posedge clk) begin
    site_outcome_t got;
    site_outcome_t want;
    if (!rst_n) begin
      for (int r = 0; r < SIDE; r++)
        for (int c = 0; c < SIDE; c++)
          lattice[r][c] = 1'b0;
      coupling_j = int'(J_RESET);
      thr_four   = '0;
      thr_eight  = '0;
      ring_head  = 0;
      ring_count = 0;
    end else begin
      // result transaction against the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        got.spin = out_mon.spin_out;
        got.flip = out_mon.flipped;
        got.de   = out_mon.energy_change;
        if (ring_count == 0) begin
          $display("%0t: unexpected result spin_out %0b flipped %0b energy_change %0d",
                   $time, got.spin, got.flip, $signed(got.de));
          mismatches++;
        end else begin
          want = ring[ring_head];
          ring_head = (ring_head + 1) % RING_DEPTH;
          ring_count--;
          if (got.spin !== want.spin) begin
            $display("%0t: spin_out expected %0b actual %0b", $time, want.spin, got.spin);
            mismatches++;
          end
          if (got.flip !== want.flip) begin
            $display("%0t: flipped expected %0b actual %0b", $time, want.flip, got.flip);
            mismatches++;
          end
          if (got.de !== want.de) begin
            $display("%0t: energy_change expected %0d actual %0d",
                     $time, $signed(want.de), $signed(got.de));
            mismatches++;
          end
        end
      end
      // input transaction: predict its outcome
      if (in_mon.valid && in_mon.ready) begin
        if (ring_count == RING_DEPTH) begin
          $display("%0t: too many outstanding transactions expected %0d actual %0d",
                   $time, RING_DEPTH, ring_count + 1);
          mismatches++;
        end else begin
          ring[(ring_head + ring_count) % RING_DEPTH] =
            update_site(in_mon.func, in_mon.row, in_mon.col,
                        in_mon.spin_in, in_mon.random_fraction);
          ring_count++;
        end
      end
      // register write
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_COUPLING:     coupling_j = int'($signed(cfg_mon.data[J_W-1:0]));
          CFG_THRESH_FOUR:  thr_four   = cfg_mon.data[FRAC_W-1:0];
          CFG_THRESH_EIGHT: thr_eight  = cfg_mon.data[FRAC_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= ring_count;
  end

endmodule

// ===== test/testbench.sv =====
module testbench;
  import isingm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1300;
  localparam int PHASES       = 6;
  localparam int TAIL_CYCLES  = 20;
  // selector code outside the enum, handled as a read
  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam logic [FRAC_W-1:0] FRAC_ONES  = '1;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              calm;
  logic [FRAC_W-1:0] cur_four;
  logic [FRAC_W-1:0] cur_eight;
  int                pending;
  int                mismatches;
  int                cycle_count;

  isingm_item_if   in_if();
  isingm_result_if out_if();
  isingm_cfg_if    cfg_if();

  ising_metropolis_site_update_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  isingm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // idle cycles before a transaction, none in calm stretches
  function automatic int idle_draw();
    return calm ? 0 : int'($urandom_range(0, 3));
  endfunction

  // coupling word with random upper bits around the 6-bit field
  function automatic logic [CFG_D_W-1:0] coupling_word(input logic [J_W-1:0] j6);
    logic [CFG_D_W-1:0] w;
    w = $urandom();
    w[J_W-1:0] = j6;
    return w;
  endfunction

  function automatic logic [FRAC_W-1:0] pick_threshold();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return FRAC_ONES;
      default: return $urandom();
    endcase
  endfunction

  // mostly sites near the wrap corner so neighbors interact
  function automatic int pick_coord();
    int k;
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, SIDE - 1));
    k = int'($urandom_range(0, 5));
    return (k < 3) ? k : SIDE - 6 + k;
  endfunction

  task automatic send_site(input logic [FUNC_W-1:0] op, input int r,
                           input int c, input logic s,
                           input logic [FRAC_W-1:0] frac);
    int gap;
    gap = idle_draw();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.func            <= op;
    in_if.row             <= ROW_W'(r);
    in_if.col             <= COL_W'(c);
    in_if.spin_in         <= s;
    in_if.random_fraction <= frac;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_random_site();
    logic [FUNC_W-1:0] op;
    logic [FRAC_W-1:0] frac;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      op = FUNC_WRITE;
    else if (pick < 45) op = FUNC_READ;
    else if (pick < 50) op = FUNC_SPARE;
    else                op = FUNC_FLIP;
    // fractions on and next to the thresholds
    case ($urandom_range(0, 7))
      0:       frac = '0;
      1:       frac = FRAC_ONES;
      2:       frac = cur_four;
      3:       frac = cur_four - 1'b1;
      4:       frac = cur_eight;
      5:       frac = cur_eight - 1'b1;
      default: frac = $urandom();
    endcase
    send_site(op, pick_coord(), pick_coord(), 1'($urandom_range(0, 1)), frac);
  endtask

  // wait until every predicted result has been taken
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_D_W-1:0] word);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= word;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic program_regs(input logic [CFG_D_W-1:0] j_word,
                              input logic [FRAC_W-1:0] t4, input logic [FRAC_W-1:0] t8);
    cfg_write(CFG_COUPLING, j_word);
    cfg_write(CFG_THRESH_FOUR, t4);
    cfg_write(CFG_THRESH_EIGHT, t8);
    cfg_if.valid <= 1'b0;
    cur_four  = t4;
    cur_eight = t8;
  endtask

  // result side backpressure
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = idle_draw();
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int phase;
    int n;
    rst_n                 <= 1'b0;
    in_if.valid           <= 1'b0;
    in_if.func            <= FUNC_READ;
    in_if.row             <= '0;
    in_if.col             <= '0;
    in_if.spin_in         <= 1'b0;
    in_if.random_fraction <= '0;
    cfg_if.valid          <= 1'b0;
    cfg_if.index          <= CFG_COUPLING;
    cfg_if.data           <= '0;
    calm      = 1'b0;
    cur_four  = '0;
    cur_eight = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: coupling one, both thresholds zero
    send_site(FUNC_WRITE, 0, 0, 1'b1, '0);
    send_site(FUNC_WRITE, SIDE - 1, SIDE - 1, 1'b1, '0);
    send_site(FUNC_READ, 0, 0, 1'b0, FRAC_ONES);
    send_site(FUNC_SPARE, SIDE - 1, SIDE - 1, 1'b1, FRAC_ONES);
    send_site(FUNC_FLIP, 0, 1, 1'b0, '0);
    send_site(FUNC_FLIP, SIDE - 1, 0, 1'b0, '0);
    send_site(FUNC_FLIP, 5, 5, 1'b1, FRAC_ONES);
    send_site(FUNC_WRITE, 5, 5, 1'b1, FRAC_ONES);
    send_site(FUNC_FLIP, 5, 5, 1'b0, '0);
    send_site(FUNC_WRITE, 0, SIDE - 1, 1'b0, FRAC_ONES);

    // strongest positive coupling, thresholds full scale
    drain_results();
    program_regs(32'hFFFF_FF90, FRAC_ONES, FRAC_ONES);
    send_site(FUNC_FLIP, 5, 5, 1'b0, '0);
    send_site(FUNC_FLIP, 5, 5, 1'b1, FRAC_ONES);
    send_site(FUNC_FLIP, 5, 5, 1'b0, FRAC_ONES);
    send_site(FUNC_FLIP, 0, 1, 1'b0, 32'hFFFF_FFFE);

    // most negative code, clamped, thresholds zero
    drain_results();
    program_regs(coupling_word(6'h20), '0, '0);
    send_site(FUNC_FLIP, 5, 5, 1'b0, FRAC_ONES);
    send_site(FUNC_FLIP, 5, 5, 1'b0, FRAC_ONES);
    send_site(FUNC_FLIP, 2, 2, 1'b0, '0);

    // zero coupling always flips
    drain_results();
    program_regs(coupling_word(6'h00), pick_threshold(), pick_threshold());
    send_site(FUNC_FLIP, 7, 7, 1'b0, FRAC_ONES);
    send_site(FUNC_READ, 7, 7, 1'b1, '0);

    // largest positive code, clamped, half and quarter thresholds
    drain_results();
    program_regs(coupling_word(6'h1F), 32'h8000_0000, 32'h4000_0000);
    send_site(FUNC_FLIP, 9, 9, 1'b0, 32'h3FFF_FFFF);
    send_site(FUNC_FLIP, 9, 9, 1'b0, 32'h3FFF_FFFF);
    send_site(FUNC_FLIP, 9, 9, 1'b0, 32'h4000_0000);

    // random phases, each with its own register setting
    for (phase = 0; phase < PHASES; phase++) begin
      drain_results();
      program_regs(coupling_word(J_W'($urandom_range(0, 63))),
                   pick_threshold(), pick_threshold());
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        send_random_site();
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
